// File: hdl/wavp_pkg.sv
// Shared types and constants for the WAV 16-bit mono PCM stream parser.
`timescale 1ns / 1ps

package wavp_pkg;

  // Parse phases, in stream order.
  typedef enum logic [3:0] {
    PH_RIFF  = 4'd0,
    PH_RSIZE = 4'd1,
    PH_WAVE  = 4'd2,
    PH_CID   = 4'd3,
    PH_CSIZE = 4'd4,
    PH_FMT   = 4'd5,
    PH_SKIP  = 4'd6,
    PH_DATA  = 4'd7,
    PH_DONE  = 4'd8
  } phase_t;

  // Result kinds.
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NO_RIFF     = 3'd0;
  localparam logic [2:0] ERR_NO_WAVE     = 3'd1;
  localparam logic [2:0] ERR_FMT_SHORT   = 3'd2;
  localparam logic [2:0] ERR_NOT_PCM16   = 3'd3;
  localparam logic [2:0] ERR_DATA_EARLY  = 3'd4;
  localparam logic [2:0] ERR_TRUNCATED   = 3'd5;

  // Chunk tags as little-endian words.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_MIN      = 32'd16;
  localparam logic [15:0] FMT_PCM      = 16'd1;
  localparam logic [15:0] FMT_MONO     = 16'd1;
  localparam logic [15:0] FMT_BITS     = 16'd16;
  localparam logic [31:0] FMT_OFF_TAG  = 32'd3;
  localparam logic [31:0] FMT_OFF_RATE = 32'd7;
  localparam logic [31:0] FMT_OFF_BITS = 32'd15;

  // Result queue depth; two free entries are needed per item.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic signed [15:0] sample;
    logic [31:0]        sample_rate;
    logic [30:0]        total_samples;
    logic [2:0]         error_code;
    logic               last;
  } out_item_t;

endpackage

// File: hdl/wav_pcm16_stream_parser.sv
// Top level of the WAV 16-bit mono PCM stream parser.
`timescale 1ns / 1ps

// The parser takes a WAV file one item (one byte) at a time on the in_ channel,
// with end_of_stream marking the final byte of the file. It checks the RIFF
// and WAVE tags, walks the chunks and, at the data chunk, sends a header item
// with the sample rate and sample count, then one item per 16-bit sample in
// Q1.15 with last set on the final one. Errors are reported as error items
// and the parser then ignores bytes until the end of the stream.
// Throughput is one byte per cycle: the whole step is one pass of logic
// between the input register and a four-entry result queue. A byte produces
// at most two results, so the input stalls only while fewer than two queue
// entries are free. A result is written into the result queue and offered on
// the out_ channel from there; the input register and the queue lie between
// a byte and its result. When the receiver stalls, the queue fills and
// in_stall rises; nothing is lost. Reset (rst_n low, synchronous) returns the
// parser to expect the RIFF tag and empties the queue; the byte after an
// end_of_stream byte starts a fresh file.

module wav_pcm16_stream_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wavp_pkg::in_item_t in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output wavp_pkg::out_item_t out_item
);

  // Input register.
  logic               in_v_r;
  wavp_pkg::in_item_t in_d_r;

  // Parser state.
  wavp_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] asm_r, asm_nxt;
  logic [31:0] clen_r, clen_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic        fmt_seen_r, fmt_seen_nxt;
  logic        fmt_ok_r, fmt_ok_nxt;
  logic        pad_r, pad_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [30:0] samples_r, samples_nxt;
  logic [7:0]  low_r, low_nxt;
  logic        halted_r, halted_nxt;

  // Result queue.
  wavp_pkg::out_item_t          q_mem [wavp_pkg::QDEPTH];
  logic [wavp_pkg::QAW-1:0]     q_wr_r, q_rd_r;
  logic [wavp_pkg::QAW:0]       q_cnt_r;

  logic                fire;
  logic                pop;
  logic                res_a_v, res_b_v;
  wavp_pkg::out_item_t res_a, res_b;
  logic                trunc_v;
  logic [30:0]         samples_dec;
  logic [1:0]          n_push;

  assign fire     = in_v_r && (q_cnt_r <= (wavp_pkg::QAW + 1)'(wavp_pkg::QDEPTH - 2));
  assign in_stall = in_v_r && !fire;
  assign pop      = out_valid && !out_stall;
  assign out_valid = (q_cnt_r != '0);
  assign samples_dec = samples_r - 31'd1;

  // One parse step for the byte held in the input register.
  always_comb begin
    phase_nxt    = phase_r;
    idx_nxt      = idx_r;
    asm_nxt      = asm_r;
    clen_nxt     = clen_r;
    skip_nxt     = skip_r;
    fmt_seen_nxt = fmt_seen_r;
    fmt_ok_nxt   = fmt_ok_r;
    pad_nxt      = pad_r;
    rate_nxt     = rate_r;
    samples_nxt  = samples_r;
    low_nxt      = low_r;
    halted_nxt   = halted_r;
    res_a_v      = 1'b0;
    res_a        = '0;
    trunc_v      = 1'b0;

    if (!halted_r && phase_r != wavp_pkg::PH_DONE) begin
      if (phase_r == wavp_pkg::PH_RIFF || phase_r == wavp_pkg::PH_RSIZE ||
          phase_r == wavp_pkg::PH_WAVE || phase_r == wavp_pkg::PH_CID ||
          phase_r == wavp_pkg::PH_CSIZE || phase_r == wavp_pkg::PH_FMT) begin
        asm_nxt = {in_d_r.byte_value, asm_r[31:8]};
        idx_nxt = idx_r + 2'd1;
      end
      case (phase_r)
        wavp_pkg::PH_RIFF: begin
          if (idx_nxt == 2'd0) begin
            if (asm_nxt != wavp_pkg::TAG_RIFF) begin
              res_a_v = 1'b1;
              res_a.result_kind = wavp_pkg::KIND_ERROR;
              res_a.error_code  = wavp_pkg::ERR_NO_RIFF;
              halted_nxt = 1'b1;
            end else begin
              phase_nxt = wavp_pkg::PH_RSIZE;
            end
          end
        end
        wavp_pkg::PH_RSIZE: begin
          if (idx_nxt == 2'd0) phase_nxt = wavp_pkg::PH_WAVE;
        end
        wavp_pkg::PH_WAVE: begin
          if (idx_nxt == 2'd0) begin
            if (asm_nxt != wavp_pkg::TAG_WAVE) begin
              res_a_v = 1'b1;
              res_a.result_kind = wavp_pkg::KIND_ERROR;
              res_a.error_code  = wavp_pkg::ERR_NO_WAVE;
              halted_nxt = 1'b1;
            end else begin
              phase_nxt = wavp_pkg::PH_CID;
            end
          end
        end
        wavp_pkg::PH_CID: begin
          // The chunk id is parked in the length register until the size arrives.
          if (idx_nxt == 2'd0) begin
            clen_nxt  = asm_nxt;
            phase_nxt = wavp_pkg::PH_CSIZE;
          end
        end
        wavp_pkg::PH_CSIZE: begin
          if (idx_nxt == 2'd0) begin
            clen_nxt = asm_nxt;
            if (clen_r == wavp_pkg::TAG_FMT) begin
              if (asm_nxt < wavp_pkg::FMT_MIN) begin
                res_a_v = 1'b1;
                res_a.result_kind = wavp_pkg::KIND_ERROR;
                res_a.error_code  = wavp_pkg::ERR_FMT_SHORT;
                halted_nxt = 1'b1;
              end else begin
                skip_nxt   = '0;
                fmt_ok_nxt = 1'b1;
                phase_nxt  = wavp_pkg::PH_FMT;
              end
            end else if (clen_r == wavp_pkg::TAG_DATA) begin
              if (!fmt_seen_r) begin
                res_a_v = 1'b1;
                res_a.result_kind = wavp_pkg::KIND_ERROR;
                res_a.error_code  = wavp_pkg::ERR_DATA_EARLY;
                halted_nxt = 1'b1;
              end else begin
                samples_nxt = asm_nxt[31:1];
                res_a_v = 1'b1;
                res_a.result_kind   = wavp_pkg::KIND_HEADER;
                res_a.sample_rate   = rate_r;
                res_a.total_samples = asm_nxt[31:1];
                res_a.last          = (asm_nxt[31:1] == '0);
                idx_nxt   = 2'd0;
                phase_nxt = (asm_nxt[31:1] == '0) ? wavp_pkg::PH_DONE
                                                  : wavp_pkg::PH_DATA;
              end
            end else begin
              skip_nxt  = asm_nxt;
              pad_nxt   = asm_nxt[0];
              phase_nxt = (asm_nxt == '0 && !asm_nxt[0]) ? wavp_pkg::PH_CID
                                                         : wavp_pkg::PH_SKIP;
            end
          end
        end
        wavp_pkg::PH_FMT: begin
          // skip_r counts fmt bytes here; checks fall on field boundaries.
          if (skip_r == wavp_pkg::FMT_OFF_TAG) begin
            if (asm_nxt[15:0] != wavp_pkg::FMT_PCM || asm_nxt[31:16] != wavp_pkg::FMT_MONO)
              fmt_ok_nxt = 1'b0;
          end else if (skip_r == wavp_pkg::FMT_OFF_RATE) begin
            rate_nxt = asm_nxt;
          end else if (skip_r == wavp_pkg::FMT_OFF_BITS) begin
            if (asm_nxt[31:16] != wavp_pkg::FMT_BITS) fmt_ok_nxt = 1'b0;
          end
          if (skip_r >= wavp_pkg::FMT_OFF_BITS) begin
            if (!fmt_ok_nxt) begin
              res_a_v = 1'b1;
              res_a.result_kind = wavp_pkg::KIND_ERROR;
              res_a.error_code  = wavp_pkg::ERR_NOT_PCM16;
              halted_nxt = 1'b1;
            end else begin
              fmt_seen_nxt = 1'b1;
              skip_nxt     = clen_r - wavp_pkg::FMT_MIN;
              pad_nxt      = clen_r[0];
              idx_nxt      = 2'd0;
              phase_nxt    = (skip_nxt == '0 && !clen_r[0]) ? wavp_pkg::PH_CID
                                                            : wavp_pkg::PH_SKIP;
            end
          end else begin
            skip_nxt = skip_r + 32'd1;
          end
        end
        wavp_pkg::PH_SKIP: begin
          if (skip_r != '0) skip_nxt = skip_r - 32'd1;
          else pad_nxt = 1'b0;
          phase_nxt = (skip_nxt == '0 && !pad_nxt) ? wavp_pkg::PH_CID
                                                   : wavp_pkg::PH_SKIP;
        end
        wavp_pkg::PH_DATA: begin
          if (idx_r == 2'd0) begin
            low_nxt = in_d_r.byte_value;
            idx_nxt = 2'd1;
          end else begin
            idx_nxt     = 2'd0;
            samples_nxt = samples_dec;
            res_a_v = 1'b1;
            res_a.result_kind = wavp_pkg::KIND_SAMPLE;
            res_a.sample      = {in_d_r.byte_value, low_r};
            res_a.last        = (samples_dec == '0);
            if (samples_dec == '0) phase_nxt = wavp_pkg::PH_DONE;
          end
        end
        default: begin
          phase_nxt = wavp_pkg::PH_DONE;
        end
      endcase
    end

    if (in_d_r.end_of_stream) begin
      trunc_v = !halted_nxt && phase_nxt != wavp_pkg::PH_DONE;
      phase_nxt    = wavp_pkg::PH_RIFF;
      idx_nxt      = '0;
      asm_nxt      = '0;
      clen_nxt     = '0;
      skip_nxt     = '0;
      fmt_seen_nxt = 1'b0;
      fmt_ok_nxt   = 1'b1;
      pad_nxt      = 1'b0;
      rate_nxt     = '0;
      samples_nxt  = '0;
      low_nxt      = '0;
      halted_nxt   = 1'b0;
    end
  end

  // Order the results: the step's own result first, then the truncation error.
  always_comb begin
    wavp_pkg::out_item_t trunc;
    trunc = '0;
    trunc.result_kind = wavp_pkg::KIND_ERROR;
    trunc.error_code  = wavp_pkg::ERR_TRUNCATED;
    res_b   = trunc;
    res_b_v = 1'b0;
    if (res_a_v) begin
      res_b_v = trunc_v;
    end
    n_push = {1'b0, res_a_v} + {1'b0, trunc_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      phase_r    <= wavp_pkg::PH_RIFF;
      idx_r      <= '0;
      asm_r      <= '0;
      clen_r     <= '0;
      skip_r     <= '0;
      fmt_seen_r <= 1'b0;
      fmt_ok_r   <= 1'b1;
      pad_r      <= 1'b0;
      rate_r     <= '0;
      samples_r  <= '0;
      low_r      <= '0;
      halted_r   <= 1'b0;
      q_wr_r     <= '0;
      q_rd_r     <= '0;
      q_cnt_r    <= '0;
    end else begin
      if (!in_stall) begin
        in_v_r <= in_valid;
        in_d_r <= in_item;
      end
      if (fire) begin
        phase_r    <= phase_nxt;
        idx_r      <= idx_nxt;
        asm_r      <= asm_nxt;
        clen_r     <= clen_nxt;
        skip_r     <= skip_nxt;
        fmt_seen_r <= fmt_seen_nxt;
        fmt_ok_r   <= fmt_ok_nxt;
        pad_r      <= pad_nxt;
        rate_r     <= rate_nxt;
        samples_r  <= samples_nxt;
        low_r      <= low_nxt;
        halted_r   <= halted_nxt;
        q_wr_r     <= q_wr_r + n_push[wavp_pkg::QAW-1:0];
      end
      if (pop) q_rd_r <= q_rd_r + 1'b1;
      q_cnt_r <= q_cnt_r + (fire ? (wavp_pkg::QAW + 1)'(n_push) : '0)
                         - (wavp_pkg::QAW + 1)'(pop);
    end
  end

  // Queue storage; only control state is reset.
  always_ff @(posedge clk) begin
    if (fire) begin
      if (res_a_v) begin
        q_mem[q_wr_r] <= res_a;
      end else if (trunc_v) begin
        q_mem[q_wr_r] <= res_b;
      end
      if (res_b_v) q_mem[q_wr_r + 1'b1] <= res_b;
    end
  end

  assign out_item = q_mem[q_rd_r];

  // The queue never overflows.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= (wavp_pkg::QAW + 1)'(wavp_pkg::QDEPTH))
    else $error("result queue overflow");

  // While sample pairs are being read, at least one sample is still owed.
  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == wavp_pkg::PH_DATA |-> samples_r != '0)
    else $error("data phase with no samples left");

  // Once halted, only the end of the stream releases the parser.
  a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r && !(fire && in_d_r.end_of_stream) |=> halted_r)
    else $error("halt released before end of stream");

endmodule
